[hw/rtl/rhc_pkg.sv]
package rhc_pkg;

    localparam int COMP_W    = 8;
    localparam int HUE_W     = 13;
    localparam int PCT_W     = 11;

    localparam int HUE_SECTOR = 960;
    localparam int HUE_TURN   = 5760;
    localparam int PCT_SCALE  = 1600;
    localparam int COMP_FULL  = 255;

    localparam int DIV_DEN_W = COMP_W;
    localparam int DIV_Q_W   = 11;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;

    localparam int                     BRI_RECIP_W = 30;
    localparam int                     BRI_SHIFT   = 27;
    localparam logic [BRI_RECIP_W-1:0] BRI_RECIP   = 30'd842152000;

    localparam logic [1:0] BASE_RED   = 2'd0;
    localparam logic [1:0] BASE_GREEN = 2'd1;
    localparam logic [1:0] BASE_BLUE  = 2'd2;
    localparam logic [1:0] BASE_TURN  = 2'd3;

    typedef logic [DIV_Q_W-1:0] div_en_t;

    typedef struct packed {
        logic [1:0] base;
        logic       neg;
    } hue_side_t;

    function automatic logic [HUE_W-1:0] hue_base(input logic [1:0] code);
        logic [HUE_W-1:0] val;
        case (code)
            BASE_RED:   val = '0;
            BASE_GREEN: val = HUE_W'(2 * HUE_SECTOR);
            BASE_BLUE:  val = HUE_W'(4 * HUE_SECTOR);
            BASE_TURN:  val = HUE_W'(HUE_TURN);
            default:    val = '0;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/rhc_div.sv]
module rhc_div (
    input  logic                            clk,
    input  rhc_pkg::div_en_t                en,
    input  logic [rhc_pkg::DIV_NUM_W-1:0]   num,
    input  logic [rhc_pkg::DIV_DEN_W-1:0]   den,
    output logic [rhc_pkg::DIV_Q_W-1:0]     quo,
    output logic                            rem_nz
);
    import rhc_pkg::*;

    logic [DIV_NUM_W-1:0] rem_reg [DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0]   quo_reg [DIV_Q_W];

    genvar k;
    generate
        for (k = 0; k < DIV_Q_W; k++)
        begin : g_step
            localparam int SH = DIV_Q_W - 1 - k;
            logic [DIV_NUM_W-1:0] rem_in;
            logic [DIV_DEN_W-1:0] den_in;
            logic [DIV_Q_W-1:0]   quo_in;
            logic [DIV_NUM_W-1:0] trial;
            logic [DIV_NUM_W-1:0] rem_next;
            logic [DIV_Q_W-1:0]   quo_next;

            if (k == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            always_comb
            begin
                trial = DIV_NUM_W'(den_in) << SH;
                if (rem_in >= trial)
                begin
                    rem_next = rem_in - trial;
                    quo_next = quo_in | (DIV_Q_W'(1) << SH);
                end
                else
                begin
                    rem_next = rem_in;
                    quo_next = quo_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    quo_reg[k] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo    = quo_reg[DIV_Q_W-1];
    assign rem_nz = (rem_reg[DIV_Q_W-1] != '0);

endmodule

[hw/rtl/rgb_to_hsv_converter.sv]
// RGB to HSV pixel converter.
// Input stream s_*: one pixel per transfer, tdata = red, green, blue (8 bits each).
// Output stream m_*: one result per pixel, tdata = hue (13 bits, 1/16 degree),
// saturation (11 bits, 1/16 percent), brightness (11 bits, 1/16 percent).
// Results leave in the order pixels arrive; there is no other state.
// Throughput: one pixel per cycle while the receiver takes results. Two front
// stages find max, min, the numerators and the brightness (a reciprocal
// multiplication), eleven stages of restoring division give one hue and
// saturation quotient bit each, and the last stage forms the hue and holds
// the output register.
// When the receiver stalls, the output holds and empty stages ahead of it
// still fill, so s_tready drops only once every stage holds a pixel.
// Reset clears all stage valid bits; nothing in flight survives reset.
module rgb_to_hsv_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // hue[12:0], saturation[23:13], brightness[34:24], zero
);
    import rhc_pkg::*;

    localparam int NST  = DIV_Q_W + 3;
    localparam int DIV0 = 2;
    localparam int LAST = NST - 1;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            en[k] = m_tready || (((~v_reg) >> k) != '0);
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    logic [COMP_W-1:0] mx_next;
    logic [COMP_W-1:0] mn_next;
    logic [COMP_W-1:0] diff_next;
    hue_side_t         side_next;

    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            mx_next = red;
            mn_next = (green < blue) ? green : blue;
            if (green >= blue)
            begin
                side_next = '{base: BASE_RED, neg: 1'b0};
                diff_next = green - blue;
            end
            else
            begin
                side_next = '{base: BASE_TURN, neg: 1'b1};
                diff_next = blue - green;
            end
        end
        else if (green >= blue)
        begin
            mx_next = green;
            mn_next = (red < blue) ? red : blue;
            if (blue >= red)
            begin
                side_next = '{base: BASE_GREEN, neg: 1'b0};
                diff_next = blue - red;
            end
            else
            begin
                side_next = '{base: BASE_GREEN, neg: 1'b1};
                diff_next = red - blue;
            end
        end
        else
        begin
            mx_next = blue;
            mn_next = (red < green) ? red : green;
            if (red >= green)
            begin
                side_next = '{base: BASE_BLUE, neg: 1'b0};
                diff_next = red - green;
            end
            else
            begin
                side_next = '{base: BASE_BLUE, neg: 1'b1};
                diff_next = green - red;
            end
        end
    end

    logic [COMP_W-1:0] mx_a_reg;
    logic [COMP_W-1:0] d_a_reg;
    logic [COMP_W-1:0] diff_a_reg;
    hue_side_t         side_a_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mx_a_reg   <= mx_next;
            d_a_reg    <= mx_next - mn_next;
            diff_a_reg <= diff_next;
            side_a_reg <= side_next;
        end
    end

    logic [DIV_NUM_W-1:0]          num_h_b_reg;
    logic [DIV_DEN_W-1:0]          den_h_b_reg;
    logic [DIV_NUM_W-1:0]          num_s_b_reg;
    logic [DIV_DEN_W-1:0]          den_s_b_reg;
    logic [PCT_W-1:0]              bri_b_reg;
    hue_side_t                     side_b_reg;
    logic [COMP_W+BRI_RECIP_W-1:0] bri_prod;

    assign bri_prod = (COMP_W+BRI_RECIP_W)'(mx_a_reg) * (COMP_W+BRI_RECIP_W)'(BRI_RECIP);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            num_h_b_reg <= DIV_NUM_W'(diff_a_reg) * DIV_NUM_W'(HUE_SECTOR);
            den_h_b_reg <= (d_a_reg == '0) ? DIV_DEN_W'(1) : d_a_reg;
            num_s_b_reg <= DIV_NUM_W'(d_a_reg) * DIV_NUM_W'(PCT_SCALE);
            den_s_b_reg <= (mx_a_reg == '0) ? DIV_DEN_W'(1) : mx_a_reg;
            bri_b_reg   <= PCT_W'(bri_prod >> BRI_SHIFT);
            side_b_reg  <= side_a_reg;
        end
    end

    div_en_t             div_en;
    logic [DIV_Q_W-1:0]  quo_h;
    logic [DIV_Q_W-1:0]  quo_s;
    logic                nz_h;
    logic                nz_s;

    assign div_en = en[DIV0 +: DIV_Q_W];

    rhc_div u_div_hue (
        .clk    (clk),
        .en     (div_en),
        .num    (num_h_b_reg),
        .den    (den_h_b_reg),
        .quo    (quo_h),
        .rem_nz (nz_h)
    );

    rhc_div u_div_sat (
        .clk    (clk),
        .en     (div_en),
        .num    (num_s_b_reg),
        .den    (den_s_b_reg),
        .quo    (quo_s),
        .rem_nz (nz_s)
    );

    hue_side_t        hside_reg [DIV_Q_W];
    logic [PCT_W-1:0] bri_d_reg [DIV_Q_W];

    always_ff @(posedge clk)
    begin
        if (div_en[0])
        begin
            hside_reg[0] <= side_b_reg;
            bri_d_reg[0] <= bri_b_reg;
        end
        for (int k = 1; k < DIV_Q_W; k++)
        begin
            if (div_en[k])
            begin
                hside_reg[k] <= hside_reg[k-1];
                bri_d_reg[k] <= bri_d_reg[k-1];
            end
        end
    end

    logic [HUE_W:0]   hue_sum;
    logic [HUE_W-1:0] hue_reg;
    logic [PCT_W-1:0] sat_reg;
    logic [PCT_W-1:0] bri_reg;

    always_comb
    begin
        if (hside_reg[DIV_Q_W-1].neg)
        begin
            hue_sum = {1'b0, hue_base(hside_reg[DIV_Q_W-1].base)}
                      - (HUE_W+1)'(quo_h) - (HUE_W+1)'(nz_h);
        end
        else
        begin
            hue_sum = {1'b0, hue_base(hside_reg[DIV_Q_W-1].base)}
                      + (HUE_W+1)'(quo_h);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            hue_reg <= hue_sum[HUE_W-1:0];
            sat_reg <= PCT_W'(quo_s);
            bri_reg <= bri_d_reg[DIV_Q_W-1];
        end
    end

    assign m_tdata = {5'b0, bri_reg, sat_reg, hue_reg};

    logic unused_nz;
    assign unused_nz = nz_s;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> hue_reg < HUE_W'(HUE_TURN))
        else $error("hue out of range");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (sat_reg <= PCT_W'(PCT_SCALE)) && (bri_reg <= PCT_W'(PCT_SCALE)))
        else $error("saturation or brightness out of range");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && bri_reg == '0 |-> sat_reg == '0 && hue_reg == '0)
        else $error("black pixel with nonzero hue or saturation");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[LAST] |-> s_tready)
        else $error("input stalled with empty output stage");

    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("transfer accepted but front stage empty");

endmodule
